[design/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, operation and status codes, and the control and status
// bundles passed between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 3;
   localparam int STATUS_W      = 2;

   // operation codes carried in a request
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd4;
   localparam logic [FUNC_W-1:0] FN_PEEK_REAR  = 3'd5;
   localparam logic [FUNC_W-1:0] FN_LIST       = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic exec;   // carry out the accepted request
      logic load;   // capture memory read data into the result register
      logic walk;   // issue the next read of a list walk
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_empty;
      logic out_last;
   } stat_type;

endpackage

[design/cdq_intf.sv]
// ----------------------------------------------------------------------------
// cdq_intf
// Valid/ready channels for deque requests and responses.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   logic                                valid;
   logic                                ready;
   logic [cdq_pkg::FUNC_W-1:0]          func;
   logic signed [cdq_pkg::WORD_W-1:0]   push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cdq_pkg::WORD_W-1:0]   word_out;
   logic [cdq_pkg::STATUS_W-1:0]        status;
   logic                                last;

   modport source (output valid, output word_out, output status, output last,
                   input ready);
   modport sink   (input valid, input word_out, input status, input last,
                   output ready);
endinterface

[design/circular_deque_top.sv]
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of signed 32-bit words in a circular store, with push,
// pop and peek at either end and a front-to-rear list walk.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_chan  in    valid/ready    func, push_value
//  rsp_chan  out   valid/ready    word_out, status, last
//
//  one request at a time: a push, or any empty result, goes from acceptance
//  straight to the response; pop, peek and each listed word first pass
//  through the registered store read. a list of n words gives n responses,
//  and the read for each word starts only once the previous one is taken.
//  reset is synchronous and empties the deque; no clearing pass is needed.
//  a stalled response holds its values and blocks new requests.
module circular_deque_top #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   cdq_req_if.sink          req_chan,
   cdq_rsp_if.source        rsp_chan
);

   cdq_pkg::cmd_type  cmd;
   cdq_pkg::stat_type stat;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_chan.func),
      .req_push_value (req_chan.push_value),
      .stat           (stat),
      .rsp_word_out   (rsp_chan.word_out),
      .rsp_status     (rsp_chan.status),
      .rsp_last       (rsp_chan.last)
   );

endmodule

[design/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = cdq_pkg::WORD_W,
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: takes one request, waits on memory reads, and
// walks a list response out one word per handshake.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [cdq_pkg::FUNC_W-1:0] req_func,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  cdq_pkg::stat_type          stat,
   output cdq_pkg::cmd_type           cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SEND = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               unique case (req_func)
                  cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
                     state_in = S_SEND;
                  end
                  cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_REAR,
                  cdq_pkg::FN_PEEK_FRONT, cdq_pkg::FN_PEEK_REAR,
                  cdq_pkg::FN_LIST: begin
                     state_in = stat.is_empty ? S_SEND : S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.load = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/cdq_dp.sv]
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: head and tail pointers, word store, list walk pointer and
// the response register.
// ----------------------------------------------------------------------------
module cdq_dp #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cdq_pkg::cmd_type                   cmd,
   input  logic [cdq_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [cdq_pkg::WORD_W-1:0]  req_push_value,
   output cdq_pkg::stat_type                  stat,
   output logic signed [cdq_pkg::WORD_W-1:0]  rsp_word_out,
   output logic [cdq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      return (i == IDX_MAX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_MAX : i - 1'b1;
   endfunction

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             empty_ff, empty_in;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             list_ff, list_in;

   logic signed [cdq_pkg::WORD_W-1:0] word_ff, word_in;
   logic [cdq_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              last_ff, last_in;

   logic                       full;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [cdq_pkg::WORD_W-1:0] rd_data;

   assign full = !empty_ff && (wrap_inc(tail_ff) == head_ff);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      walk_in   = walk_ff;
      cnt_in    = cnt_ff;
      list_in   = list_ff;
      word_in   = word_ff;
      status_in = status_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_en     = 1'b0;
      rd_addr   = walk_ff;

      if (cmd.exec) begin
         word_in   = '0;
         last_in   = 1'b1;
         status_in = cdq_pkg::STAT_OK;
         list_in   = (req_func == cdq_pkg::FN_LIST);
         unique case (req_func)
            cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
               if (full) begin
                  status_in = cdq_pkg::STAT_FULL;
               end else if (empty_ff) begin
                  // first word always lands in entry zero
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
               end else if (req_func == cdq_pkg::FN_PUSH_FRONT) begin
                  wr_en   = 1'b1;
                  wr_addr = wrap_dec(head_ff);
                  head_in = wrap_dec(head_ff);
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = wrap_inc(tail_ff);
                  tail_in = wrap_inc(tail_ff);
               end
            end
            cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_REAR,
            cdq_pkg::FN_PEEK_FRONT, cdq_pkg::FN_PEEK_REAR: begin
               if (empty_ff) begin
                  status_in = cdq_pkg::STAT_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = (req_func == cdq_pkg::FN_POP_FRONT ||
                             req_func == cdq_pkg::FN_PEEK_FRONT) ? head_ff : tail_ff;
                  if (req_func == cdq_pkg::FN_POP_FRONT ||
                      req_func == cdq_pkg::FN_POP_REAR) begin
                     if (head_ff == tail_ff) begin
                        empty_in = 1'b1;
                        head_in  = '0;
                        tail_in  = '0;
                     end else if (req_func == cdq_pkg::FN_POP_FRONT) begin
                        head_in = wrap_inc(head_ff);
                     end else begin
                        tail_in = wrap_dec(tail_ff);
                     end
                  end
               end
            end
            cdq_pkg::FN_LIST: begin
               if (empty_ff) begin
                  status_in = cdq_pkg::STAT_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = head_ff;
                  walk_in = head_ff;
                  cnt_in  = '0;
               end
            end
            default: begin
               list_in = 1'b0;
            end
         endcase
      end

      if (cmd.load) begin
         word_in = $signed(rd_data);
         if (list_ff) begin
            // walk_ff still points at the word just read
            last_in = (walk_ff == tail_ff) || (cnt_ff == IDX_MAX);
            walk_in = wrap_inc(walk_ff);
            cnt_in  = cnt_ff + 1'b1;
         end else begin
            last_in = 1'b1;
         end
      end

      if (cmd.walk) begin
         rd_en   = 1'b1;
         rd_addr = walk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         list_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         list_ff  <= list_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff   <= walk_in;
      cnt_ff    <= cnt_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   cdq_ram #(
      .WIDTH (cdq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.is_empty = empty_ff;
   assign stat.out_last = last_ff;
   assign rsp_word_out  = word_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_deque_top. Requests are checked against a
// behavioral deque kept in the bench: directed cases at the empty and full
// boundaries, then random push/pop/peek/list traffic, with random stalls on
// both channels in every phase but the last.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH = 8;
   localparam logic [cdq_pkg::FUNC_W-1:0] FN_UNUSED = 3'd7;
   localparam logic signed [cdq_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [cdq_pkg::WORD_W-1:0] WORD_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [cdq_pkg::WORD_W-1:0] word;
      logic [cdq_pkg::STATUS_W-1:0]      status;
      logic                              last;
   } deque_rsp_type;

   logic clock;
   logic reset;

   cdq_req_if req_if ();
   cdq_rsp_if rsp_if ();

   circular_deque_top #(.DEPTH(DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // bench copy of the deque
   logic signed [cdq_pkg::WORD_W-1:0] dq_store [DEPTH];
   int                                dq_head;
   int                                dq_tail;
   bit                                dq_empty;

   deque_rsp_type pending_rsp [$];
   bit            failed;
   bit            idle_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // expected responses for one accepted request
   function automatic void compute_deque_results(
      input logic [cdq_pkg::FUNC_W-1:0]        fn,
      input logic signed [cdq_pkg::WORD_W-1:0] val);
      logic signed [cdq_pkg::WORD_W-1:0] word;
      int pos;
      int k;
      bit fin;
      case (fn)
         cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
            if (!dq_empty && (dq_tail + 1) % DEPTH == dq_head) begin
               pending_rsp.push_back('{word: '0, status: cdq_pkg::STAT_FULL, last: 1'b1});
            end else begin
               if (dq_empty) begin
                  dq_head     = 0;
                  dq_tail     = 0;
                  dq_store[0] = val;
                  dq_empty    = 1'b0;
               end else if (fn == cdq_pkg::FN_PUSH_FRONT) begin
                  dq_head           = (dq_head + DEPTH - 1) % DEPTH;
                  dq_store[dq_head] = val;
               end else begin
                  dq_tail           = (dq_tail + 1) % DEPTH;
                  dq_store[dq_tail] = val;
               end
               pending_rsp.push_back('{word: '0, status: cdq_pkg::STAT_OK, last: 1'b1});
            end
         end
         cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_REAR,
         cdq_pkg::FN_PEEK_FRONT, cdq_pkg::FN_PEEK_REAR: begin
            if (dq_empty) begin
               pending_rsp.push_back('{word: '0, status: cdq_pkg::STAT_EMPTY, last: 1'b1});
            end else begin
               word = (fn == cdq_pkg::FN_POP_FRONT || fn == cdq_pkg::FN_PEEK_FRONT) ?
                      dq_store[dq_head] : dq_store[dq_tail];
               if (fn == cdq_pkg::FN_POP_FRONT || fn == cdq_pkg::FN_POP_REAR) begin
                  // removing the only word resets both ends
                  if (dq_head == dq_tail) begin
                     dq_empty = 1'b1;
                     dq_head  = 0;
                     dq_tail  = 0;
                  end else if (fn == cdq_pkg::FN_POP_FRONT) begin
                     dq_head = (dq_head + 1) % DEPTH;
                  end else begin
                     dq_tail = (dq_tail + DEPTH - 1) % DEPTH;
                  end
               end
               pending_rsp.push_back('{word: word, status: cdq_pkg::STAT_OK, last: 1'b1});
            end
         end
         cdq_pkg::FN_LIST: begin
            if (dq_empty) begin
               pending_rsp.push_back('{word: '0, status: cdq_pkg::STAT_EMPTY, last: 1'b1});
            end else begin
               pos = dq_head;
               for (k = 0; k < DEPTH; k++) begin
                  fin = (pos == dq_tail) || (k == DEPTH - 1);
                  pending_rsp.push_back('{word: dq_store[pos], status: cdq_pkg::STAT_OK,
                                          last: fin});
                  if (fin) break;
                  pos = (pos + 1) % DEPTH;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // one request; returns at the edge where it is accepted, valid left high
   task automatic send_request(input logic [cdq_pkg::FUNC_W-1:0]        fn,
                               input logic signed [cdq_pkg::WORD_W-1:0] val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= fn;
      req_if.push_value <= val;
      do @(posedge clock); while (!req_if.ready);
      compute_deque_results(fn, val);
   endtask

   task automatic test_empty_ops();
      send_request(cdq_pkg::FN_POP_FRONT, 32'sd1);
      send_request(cdq_pkg::FN_POP_REAR, 32'sd2);
      send_request(cdq_pkg::FN_PEEK_FRONT, 32'sd3);
      send_request(cdq_pkg::FN_PEEK_REAR, 32'sd4);
      send_request(cdq_pkg::FN_LIST, 32'sd5);
      send_request(FN_UNUSED, WORD_MAX);
      // single word taken from either end
      send_request(cdq_pkg::FN_PUSH_REAR, 32'sd77);
      send_request(cdq_pkg::FN_POP_FRONT, '0);
      send_request(cdq_pkg::FN_PUSH_FRONT, -32'sd77);
      send_request(cdq_pkg::FN_POP_REAR, '0);
   endtask

   task automatic test_fill_to_full();
      send_request(cdq_pkg::FN_PUSH_FRONT, WORD_MAX);
      send_request(cdq_pkg::FN_PUSH_REAR, WORD_MIN);
      send_request(cdq_pkg::FN_PUSH_FRONT, '0);
      send_request(cdq_pkg::FN_PUSH_REAR, -32'sd1);
      send_request(cdq_pkg::FN_PUSH_FRONT, 32'sh55555555);
      send_request(cdq_pkg::FN_PUSH_REAR, 32'shaaaaaaaa);
      send_request(cdq_pkg::FN_PUSH_FRONT, 32'sh0000ffff);
      send_request(cdq_pkg::FN_PUSH_REAR, 32'shffff0000);
      send_request(cdq_pkg::FN_PUSH_FRONT, 32'sd9);
      send_request(cdq_pkg::FN_PUSH_REAR, 32'sd10);
      send_request(cdq_pkg::FN_LIST, '0);
      send_request(cdq_pkg::FN_PEEK_FRONT, '0);
      send_request(cdq_pkg::FN_PEEK_REAR, '0);
   endtask

   task automatic test_random_mix(input int count, input int push_pct);
      int n;
      int pick;
      logic [cdq_pkg::FUNC_W-1:0] fn;
      logic signed [cdq_pkg::WORD_W-1:0] val;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            fn = $urandom_range(0, 1) ? cdq_pkg::FN_PUSH_REAR : cdq_pkg::FN_PUSH_FRONT;
         end else if (pick < push_pct + (100 - push_pct) / 2) begin
            fn = $urandom_range(0, 1) ? cdq_pkg::FN_POP_REAR : cdq_pkg::FN_POP_FRONT;
         end else begin
            case ($urandom_range(0, 9))
               0, 1:    fn = cdq_pkg::FN_PEEK_FRONT;
               2, 3:    fn = cdq_pkg::FN_PEEK_REAR;
               9:       fn = FN_UNUSED;
               default: fn = cdq_pkg::FN_LIST;
            endcase
         end
         case ($urandom_range(0, 7))
            0:       val = WORD_MAX;
            1:       val = WORD_MIN;
            default: val = $urandom;
         endcase
         send_request(fn, val);
      end
   endtask

   // response side stalls
   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      deque_rsp_type exp_rsp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: word_out %0d status %0d last %0b",
                   rsp_if.word_out, rsp_if.status, rsp_if.last);
            failed = 1'b1;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_if.word_out !== exp_rsp.word) begin
               $error("word_out: expected %0d, actual %0d", exp_rsp.word, rsp_if.word_out);
               failed = 1'b1;
            end
            if (rsp_if.status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_if.status);
               failed = 1'b1;
            end
            if (rsp_if.last !== exp_rsp.last) begin
               $error("last: expected %0b, actual %0b", exp_rsp.last, rsp_if.last);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      failed            = 1'b0;
      idle_on           = 1'b0;
      dq_head           = 0;
      dq_tail           = 0;
      dq_empty          = 1'b1;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.func       <= cdq_pkg::FN_PUSH_FRONT;
      req_if.push_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      test_empty_ops();
      test_fill_to_full();
      test_random_mix(30, 70);
      test_random_mix(30, 30);
      test_random_mix(20, 50);
      idle_on = 1'b0;
      test_random_mix(30, 50);
      req_if.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
